// ===== src/auto_repeat_dial_editor_core_macros.svh =====
// Assertion macros shared by the dial editor RTL.
`ifndef AUTO_REPEAT_DIAL_EDITOR_CORE_MACROS_SVH
`define AUTO_REPEAT_DIAL_EDITOR_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ARDC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ARDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ARDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ardc_pkg.sv =====
// Shared types and constants for the auto-repeat dial editor.
`default_nettype none

package ardc_pkg;

  localparam int NUM_DIALS_DEF   = 12;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int NUM_REPEAT_KEYS = 4;

  localparam int TICK_W  = 32;
  localparam int DELAY_W = 16;
  localparam int STEP_W  = 8;
  localparam int INDEX_W = 4;
  localparam int KEYS_W  = 8;

  localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST   = 16'd50;
  localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 16'd10;
  localparam logic [STEP_W-1:0]  STEP_MAX            = 8'hFF;

  // Key bit positions in keys_held.
  localparam int KEY_UP    = 0;
  localparam int KEY_DOWN  = 1;
  localparam int KEY_LEFT  = 2;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_A     = 4;
  localparam int KEY_X     = 5;
  localparam int KEY_Y     = 6;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_LOAD = 1'b1
  } req_type_t;

  typedef enum logic {
    REG_INITIAL_DELAY   = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DELAY_W-1:0] initial_delay;
    logic [DELAY_W-1:0] repeat_interval;
  } rpt_cfg_t;

  typedef struct packed {
    logic                       advance;
    logic [TICK_W-1:0]          tick;
    logic [NUM_REPEAT_KEYS-1:0] keys;
  } rpt_req_t;

endpackage

`default_nettype wire

// ===== src/ardc_key_repeat.sv =====
// Typematic repeat timers for the four direction keys.
`default_nettype none

module ardc_key_repeat (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ardc_pkg::rpt_cfg_t                  cfg,
  input  wire ardc_pkg::rpt_req_t                  req,
  output logic [ardc_pkg::NUM_REPEAT_KEYS-1:0]     fire
);
  import ardc_pkg::*;

  logic [NUM_REPEAT_KEYS-1:0]             key_down;
  logic [NUM_REPEAT_KEYS-1:0][TICK_W-1:0] next_fire;
  logic [NUM_REPEAT_KEYS-1:0]             due;

  // A held key fires on its first tick, then whenever its deadline has come.
  always_comb begin
    for (int i = 0; i < NUM_REPEAT_KEYS; i++) begin
      due[i]  = req.tick >= next_fire[i];
      fire[i] = req.keys[i] && (!key_down[i] || due[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down  <= '0;
      next_fire <= '0;
    end else if (req.advance) begin
      for (int i = 0; i < NUM_REPEAT_KEYS; i++) begin
        if (!req.keys[i]) begin
          key_down[i]  <= 1'b0;
          next_fire[i] <= '0;
        end else if (!key_down[i]) begin
          key_down[i]  <= 1'b1;
          next_fire[i] <= req.tick + TICK_W'(cfg.initial_delay);
        end else if (due[i]) begin
          next_fire[i] <= req.tick + TICK_W'(cfg.repeat_interval);
        end
      end
    end
  end

  `include "auto_repeat_dial_editor_core_macros.svh"

  `ARDC_ASSERT_SAME(a_fire_needs_key, req.advance, (fire & ~req.keys) == '0, "key fired while released")
  `ARDC_ASSERT_NEXT(a_release_clears, req.advance, (key_down & ~$past(req.keys)) == '0, "released key still down")
  `ARDC_ASSERT_NEXT(a_idle_holds, !req.advance, $stable(key_down) && $stable(next_fire), "repeat state moved without a tick")

endmodule

`default_nettype wire

// ===== src/auto_repeat_dial_editor_core.sv =====
// Top level of the auto-repeat dial editor: stream ports, dial bank, edit datapath.
`default_nettype none

// A bank of NUM_DIALS signed dials edited from sampled keys. Each input
// transaction is either a tick (tuser = 0) carrying a tick number and the held
// keys, or a load (tuser = 1) that writes one dial's limits, step and default
// and sets its value to the default. Up/down move the selection, left/right
// step the selected dial down/up clamped to its limits, X restores all
// defaults, Y forces a step of 1 and A doubles it (saturating at 255). The
// direction keys auto-repeat: they fire on press, again initial_delay ticks
// later, then every repeat_interval ticks while held. Every transaction yields
// exactly one result transaction. Rate: one transaction per clock cycle,
// sustained while m_tready stays high; each result is registered. The input
// register feeds one combinational pass (dial select, subtract/clamp,
// add/clamp) into the result register, so throughput is set by that register
// pair and by the consumer's tready alone. Write the delay registers only
// while no transaction is in flight; dials read before their first load give
// undefined values.
module auto_repeat_dial_editor_core #(
  parameter  int NUM_DIALS  = ardc_pkg::NUM_DIALS_DEF,
  parameter  int VALUE_BITS = ardc_pkg::VALUE_BITS_DEF,
  localparam int IN_BITS    = 53 + 3 * VALUE_BITS,
  localparam int S_W        = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 13 + 2 * VALUE_BITS,
  localparam int M_W        = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire ardc_pkg::cfg_reg_t              cfg_addr,
  input  wire logic [ardc_pkg::DELAY_W-1:0]    cfg_wdata,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // low to high: tick_count, keys_held, play_edge, dial_index, dial_min,
  // dial_max, dial_step, dial_default, zero fill
  input  wire logic [S_W-1:0]                  s_tdata,
  // req_type
  input  wire ardc_pkg::req_type_t             s_tuser,
  // result stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // low to high: selected_dial, selected_value, read_value, play_trigger,
  // active_step, zero fill
  output logic [M_W-1:0]                       m_tdata
);
  import ardc_pkg::*;

  localparam int SEL_W = $clog2(NUM_DIALS);

  // input field offsets
  localparam int TICK_LSB = 0;
  localparam int KEYS_LSB = TICK_LSB + TICK_W;
  localparam int EDGE_LSB = KEYS_LSB + KEYS_W;
  localparam int IDX_LSB  = EDGE_LSB + 1;
  localparam int MIN_LSB  = IDX_LSB + INDEX_W;
  localparam int MAX_LSB  = MIN_LSB + VALUE_BITS;
  localparam int STEP_LSB = MAX_LSB + VALUE_BITS;
  localparam int DEF_LSB  = STEP_LSB + STEP_W;

  // result field offsets
  localparam int PLAY_OLSB = INDEX_W + 2 * VALUE_BITS;
  localparam int STEP_OLSB = PLAY_OLSB + 1;

  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(NUM_DIALS - 1);

  // configuration registers
  rpt_cfg_t rpt_cfg;

  // input register
  logic               in_valid;
  req_type_t          in_req;
  logic [IN_BITS-1:0] in_data;
  logic               advance;
  logic               tick_adv;
  logic               load_adv;

  // fields of the held item
  logic [TICK_W-1:0]            f_tick;
  logic [KEYS_W-1:0]            f_keys;
  logic                         f_edge;
  logic [INDEX_W-1:0]           f_idx;
  logic signed [VALUE_BITS-1:0] f_min;
  logic signed [VALUE_BITS-1:0] f_max;
  logic [STEP_W-1:0]            f_step;
  logic signed [VALUE_BITS-1:0] f_def;

  // dial bank and selection
  logic signed [VALUE_BITS-1:0] dial_value [NUM_DIALS];
  logic signed [VALUE_BITS-1:0] dial_low   [NUM_DIALS];
  logic signed [VALUE_BITS-1:0] dial_high  [NUM_DIALS];
  logic [STEP_W-1:0]            dial_inc   [NUM_DIALS];
  logic signed [VALUE_BITS-1:0] dial_start [NUM_DIALS];
  logic [SEL_W-1:0]             selection;

  // repeat timers
  rpt_req_t                   rpt_req;
  logic [NUM_REPEAT_KEYS-1:0] fire;

  // edit datapath
  logic [STEP_W-1:0]            inc;
  logic [STEP_W:0]              dbl;
  logic [STEP_W-1:0]            step;
  logic [SEL_W-1:0]             sel_a;
  logic [SEL_W-1:0]             sel_b;
  logic [SEL_W-1:0]             idx_sel;
  logic                         idx_ok;
  logic                         moved;
  logic signed [VALUE_BITS-1:0] cur;
  logic signed [VALUE_BITS-1:0] lv;
  logic signed [VALUE_BITS-1:0] rv;
  logic signed [VALUE_BITS:0]   cur_w;
  logic signed [VALUE_BITS:0]   lo_w;
  logic signed [VALUE_BITS:0]   hi_w;
  logic signed [VALUE_BITS:0]   lv_w;
  logic signed [VALUE_BITS:0]   step_w;
  logic signed [VALUE_BITS:0]   dn;
  logic signed [VALUE_BITS:0]   up;
  logic signed [VALUE_BITS-1:0] rd_base;

  // result fields
  logic [SEL_W-1:0]             res_sel;
  logic signed [VALUE_BITS-1:0] res_sel_val;
  logic signed [VALUE_BITS-1:0] res_rd;
  logic                         res_play;
  logic [STEP_W-1:0]            res_step;
  logic [OUT_BITS-1:0]          res;

  // ---------------------------------------------------------------------
  // Configuration: write-only delay registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_cfg.initial_delay   <= INITIAL_DELAY_RST;
      rpt_cfg.repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INITIAL_DELAY:   rpt_cfg.initial_delay   <= cfg_wdata;
        REG_REPEAT_INTERVAL: rpt_cfg.repeat_interval <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the held item advances into the result register whenever
  // that register is empty or being drained; a new item is taken in the
  // same cycle.
  // ---------------------------------------------------------------------
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign tick_adv = advance && (in_req == REQ_TICK);
  assign load_adv = advance && (in_req == REQ_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_data <= s_tdata[IN_BITS-1:0];
    end
  end

  assign f_tick = in_data[TICK_LSB +: TICK_W];
  assign f_keys = in_data[KEYS_LSB +: KEYS_W];
  assign f_edge = in_data[EDGE_LSB];
  assign f_idx  = in_data[IDX_LSB +: INDEX_W];
  assign f_min  = in_data[MIN_LSB +: VALUE_BITS];
  assign f_max  = in_data[MAX_LSB +: VALUE_BITS];
  assign f_step = in_data[STEP_LSB +: STEP_W];
  assign f_def  = in_data[DEF_LSB +: VALUE_BITS];

  // ---------------------------------------------------------------------
  // Repeat timers see only tick items.
  // ---------------------------------------------------------------------
  assign rpt_req.advance = tick_adv;
  assign rpt_req.tick    = f_tick;
  assign rpt_req.keys    = f_keys[NUM_REPEAT_KEYS-1:0];

  ardc_key_repeat u_key_repeat (
    .clk  (clk),
    .rst  (rst),
    .cfg  (rpt_cfg),
    .req  (rpt_req),
    .fire (fire)
  );

  // ---------------------------------------------------------------------
  // Edit datapath.
  // ---------------------------------------------------------------------
  assign idx_ok  = {1'b0, f_idx} < (INDEX_W + 1)'(NUM_DIALS);
  assign idx_sel = f_idx[SEL_W-1:0];
  assign moved   = fire[KEY_LEFT] || fire[KEY_RIGHT];

  always_comb begin
    // Step comes from the dial selected at the start of the tick.
    inc = dial_inc[selection];
    dbl = {inc, 1'b0};
    if (f_keys[KEY_Y]) begin
      step = STEP_W'(1);
    end else if (f_keys[KEY_A]) begin
      step = dbl[STEP_W] ? STEP_MAX : dbl[STEP_W-1:0];
    end else begin
      step = inc;
    end

    // Up is handled before down; both clamp to the bank.
    sel_a = (fire[KEY_UP] && selection != '0) ? selection - SEL_W'(1) : selection;
    sel_b = (fire[KEY_DOWN] && sel_a != SEL_LAST) ? sel_a + SEL_W'(1) : sel_a;

    // Left then right on the dial selected after the moves; X restores first.
    cur    = f_keys[KEY_X] ? dial_start[sel_b] : dial_value[sel_b];
    cur_w  = (VALUE_BITS + 1)'(cur);
    lo_w   = (VALUE_BITS + 1)'(dial_low[sel_b]);
    hi_w   = (VALUE_BITS + 1)'(dial_high[sel_b]);
    step_w = {{(VALUE_BITS + 1 - STEP_W){1'b0}}, step};

    dn = cur_w - step_w;
    if (!fire[KEY_LEFT]) begin
      lv = cur;
    end else if (dn < lo_w) begin
      lv = dial_low[sel_b];
    end else begin
      lv = dn[VALUE_BITS-1:0];
    end

    lv_w = (VALUE_BITS + 1)'(lv);
    up   = lv_w + step_w;
    if (!fire[KEY_RIGHT]) begin
      rv = lv;
    end else if (up > hi_w) begin
      rv = dial_high[sel_b];
    end else begin
      rv = up[VALUE_BITS-1:0];
    end

    // Result fields as seen after the item.
    if (in_req == REQ_TICK) begin
      rd_base     = f_keys[KEY_X] ? dial_start[idx_sel] : dial_value[idx_sel];
      res_sel     = sel_b;
      res_sel_val = rv;
      if (!idx_ok) begin
        res_rd = '0;
      end else if (moved && idx_sel == sel_b) begin
        res_rd = rv;
      end else begin
        res_rd = rd_base;
      end
      res_play = f_edge;
      res_step = step;
    end else begin
      rd_base     = dial_value[idx_sel];
      res_sel     = selection;
      res_sel_val = (idx_ok && idx_sel == selection) ? f_def : dial_value[selection];
      res_rd      = idx_ok ? f_def : '0;
      res_play    = 1'b0;
      res_step    = '0;
    end
  end

  assign res = {res_step, res_play, res_rd, res_sel_val, INDEX_W'(res_sel)};

  // ---------------------------------------------------------------------
  // Dial bank and selection update.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      selection <= '0;
    end else if (tick_adv) begin
      selection <= sel_b;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIALS; i++) begin
      if (load_adv && idx_ok && idx_sel == SEL_W'(i)) begin
        dial_low[i]   <= f_min;
        dial_high[i]  <= f_max;
        dial_inc[i]   <= f_step;
        dial_start[i] <= f_def;
        dial_value[i] <= f_def;
      end else if (tick_adv) begin
        if (moved && sel_b == SEL_W'(i)) begin
          dial_value[i] <= rv;
        end else if (f_keys[KEY_X]) begin
          dial_value[i] <= dial_start[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold until the consumer takes it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= M_W'(res);
    end
  end

  `include "auto_repeat_dial_editor_core_macros.svh"

  `ARDC_ASSERT_ALWAYS(a_sel_range, {1'b0, selection} < (SEL_W + 1)'(NUM_DIALS), "selection beyond dial bank")
  `ARDC_ASSERT_NEXT(a_sel_frozen, !tick_adv, $stable(selection), "selection moved without a tick")
  `ARDC_ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "advanced item left no result")
  `ARDC_ASSERT_NEXT(a_load_quiet, load_adv, m_tdata[STEP_OLSB +: STEP_W] == '0 && !m_tdata[PLAY_OLSB], "load result carries step or play")

endmodule

`default_nettype wire

// ===== verif/ardc_dial_checker.sv =====
// Checker for the auto-repeat dial editor: predicts every result and compares it.
module ardc_dial_checker #(
  parameter int S_W = 104,
  parameter int M_W = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  ardc_pkg::cfg_reg_t             cfg_addr,
  input  logic [ardc_pkg::DELAY_W-1:0]   cfg_wdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [S_W-1:0]                 s_tdata,
  input  ardc_pkg::req_type_t            s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [M_W-1:0]                 m_tdata,
  output int                             mismatches,
  output int                             waiting,
  output int                             compared
);
  import ardc_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] dial;
    logic signed [15:0] value;
    logic signed [15:0] readback;
    logic               play;
    logic [STEP_W-1:0]  step;
  } dial_report_t;

  dial_report_t due_reports[$];
  dial_report_t want, got;

  // Shadow copy of the editor state.
  logic [INDEX_W-1:0]         sel;
  logic signed [15:0]         val  [NUM_DIALS_DEF];
  logic signed [15:0]         lo   [NUM_DIALS_DEF];
  logic signed [15:0]         hi   [NUM_DIALS_DEF];
  logic signed [15:0]         dflt [NUM_DIALS_DEF];
  logic [STEP_W-1:0]          inc  [NUM_DIALS_DEF];
  logic [NUM_REPEAT_KEYS-1:0] held;
  logic [TICK_W-1:0]          fire_at [NUM_REPEAT_KEYS];
  logic [DELAY_W-1:0]         first_dly, again_dly;

  initial begin
    mismatches = 0;
    waiting    = 0;
    compared   = 0;
  end

  // Apply one input transaction to the shadow state and return its result.
  function automatic dial_report_t predict_report(input req_type_t req,
                                                  input logic [S_W-1:0] d);
    logic [TICK_W-1:0]  tick;
    logic [KEYS_W-1:0]  keys;
    logic [INDEX_W-1:0] idx;
    int                 amount;
    int                 v;
    int                 k;
    dial_report_t       r;
    tick = d[31:0];
    keys = d[39:32];
    idx  = d[44:41];
    r    = '0;
    if (req == REQ_LOAD) begin
      if (idx < NUM_DIALS_DEF) begin
        lo[idx]   = d[60:45];
        hi[idx]   = d[76:61];
        inc[idx]  = d[84:77];
        dflt[idx] = d[100:85];
        val[idx]  = d[100:85];
      end
    end else begin
      r.play = d[40];
      // step comes from the dial selected before any key moves it
      amount = int'(inc[sel]);
      if (keys[KEY_Y]) begin
        amount = 1;
      end else if (keys[KEY_A]) begin
        amount = (2 * amount > STEP_MAX) ? STEP_MAX : 2 * amount;
      end
      if (keys[KEY_X]) begin
        for (k = 0; k < NUM_DIALS_DEF; k++) val[k] = dflt[k];
      end
      for (k = 0; k < NUM_REPEAT_KEYS; k++) begin
        if (!keys[k]) begin
          held[k]    = 1'b0;
          fire_at[k] = '0;
        end else if (!held[k] || tick >= fire_at[k]) begin
          fire_at[k] = tick + (held[k] ? again_dly : first_dly);
          held[k]    = 1'b1;
          case (k)
            KEY_UP: begin
              if (sel > 0) sel = sel - 1'b1;
            end
            KEY_DOWN: begin
              if (sel < NUM_DIALS_DEF - 1) sel = sel + 1'b1;
            end
            KEY_LEFT: begin
              v = val[sel] - amount;
              if (v < lo[sel]) v = lo[sel];
              val[sel] = 16'(v);
            end
            default: begin
              v = val[sel] + amount;
              if (v > hi[sel]) v = hi[sel];
              val[sel] = 16'(v);
            end
          endcase
        end
      end
      r.step = amount[STEP_W-1:0];
    end
    r.dial     = sel;
    r.value    = val[sel];
    r.readback = (idx < NUM_DIALS_DEF) ? val[idx] : '0;
    return r;
  endfunction

  task automatic report_field(input string field, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected %0d, got %0d", compared, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sel       = '0;
      held      = '0;
      first_dly = INITIAL_DELAY_RST;
      again_dly = REPEAT_INTERVAL_RST;
      for (int k = 0; k < NUM_REPEAT_KEYS; k++) fire_at[k] = '0;
      due_reports.delete();
      waiting = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_INITIAL_DELAY) first_dly = cfg_wdata;
        else again_dly = cfg_wdata;
      end
      if (s_tvalid && s_tready) due_reports.push_back(predict_report(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got.dial     = m_tdata[3:0];
        got.value    = m_tdata[19:4];
        got.readback = m_tdata[35:20];
        got.play     = m_tdata[36];
        got.step     = m_tdata[44:37];
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %h", m_tdata);
        end else begin
          want = due_reports.pop_front();
          compared++;
          if (got.dial !== want.dial) report_field("selected_dial", want.dial, got.dial);
          if (got.value !== want.value)
            report_field("selected_value", want.value, got.value);
          if (got.readback !== want.readback)
            report_field("read_value", want.readback, got.readback);
          if (got.play !== want.play) report_field("play_trigger", want.play, got.play);
          if (got.step !== want.step) report_field("active_step", want.step, got.step);
        end
      end
      waiting = due_reports.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the dial editor testbench: clock, reset, stimulus, result sink and verdict.
module tb_top;
  import ardc_pkg::*;

  localparam int S_W = ((53 + 3 * VALUE_BITS_DEF + 7) / 8) * 8;
  localparam int M_W = ((13 + 2 * VALUE_BITS_DEF + 7) / 8) * 8;

  // Single-key masks for keys_held; B sits on bit 7 and has no package name.
  localparam logic [KEYS_W-1:0] K_UP    = 8'(1 << KEY_UP);
  localparam logic [KEYS_W-1:0] K_DOWN  = 8'(1 << KEY_DOWN);
  localparam logic [KEYS_W-1:0] K_LEFT  = 8'(1 << KEY_LEFT);
  localparam logic [KEYS_W-1:0] K_RIGHT = 8'(1 << KEY_RIGHT);
  localparam logic [KEYS_W-1:0] K_A     = 8'(1 << KEY_A);
  localparam logic [KEYS_W-1:0] K_X     = 8'(1 << KEY_X);
  localparam logic [KEYS_W-1:0] K_Y     = 8'(1 << KEY_Y);
  localparam logic [KEYS_W-1:0] K_B     = 8'h80;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  cfg_reg_t           cfg_addr;
  logic [DELAY_W-1:0] cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [S_W-1:0]     s_tdata;
  req_type_t          s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [M_W-1:0]     m_tdata;

  int   dial_mismatches;
  int   dial_waiting;
  int   dial_compared;
  logic idle_on = 1'b1;
  int   loads_sent = 0;
  int   ticks_sent = 0;
  int   settings_used = 0;

  always #2 clk = ~clk;

  auto_repeat_dial_editor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ardc_dial_checker #(.S_W(S_W), .M_W(M_W)) dial_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (dial_mismatches),
    .waiting    (dial_waiting),
    .compared   (dial_compared)
  );

  // Offer one transaction, starting and ending on a falling edge. A random gap,
  // possibly none, comes first while idling is on; with no gap, tvalid stays
  // high from the previous transaction so it is never dropped and raised in
  // the same step.
  task automatic push_item(input req_type_t req, input logic [S_W-1:0] data);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Tick transaction; the load fields carry random junk the block must ignore.
  task automatic send_tick(input logic [TICK_W-1:0] t, input logic [KEYS_W-1:0] k,
                           input logic play, input logic [INDEX_W-1:0] idx);
    push_item(REQ_TICK, S_W'({16'($urandom), 8'($urandom), 16'($urandom),
                              16'($urandom), idx, play, k, t}));
    ticks_sent++;
  endtask

  // Load transaction; tick, keys and play bit carry random junk.
  task automatic send_load(input logic [INDEX_W-1:0] idx, input int lo, input int hi,
                           input int step, input int dflt);
    push_item(REQ_LOAD, S_W'({16'(dflt), 8'(step), 16'(hi), 16'(lo), idx,
                              1'($urandom), 8'($urandom), 32'($urandom)}));
    loads_sent++;
  endtask

  // Drop tvalid and hold off until every outstanding result has returned,
  // then give the pipeline a little slack.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (dial_waiting != 0);
    repeat (2) @(negedge clk);
  endtask

  // Write both delay registers while the block is idle.
  task automatic set_delays(input int first, input int again);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_INITIAL_DELAY;
    cfg_wdata <= first[DELAY_W-1:0];
    @(negedge clk);
    cfg_addr  <= REG_REPEAT_INTERVAL;
    cfg_wdata <= again[DELAY_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Result sink: after each accepted result, stall at random while idling is on.
  initial begin : result_sink
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) hold = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [TICK_W-1:0] tick;
    logic [KEYS_W-1:0] keys;
    logic [KEYS_W-1:0] sent_keys;
    int                first;
    int                again;
    int                adv_max;
    int                phase;
    int                n;
    int                b;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = REG_INITIAL_DELAY;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_TICK;

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load every dial before the first tick so no tick reads an unwritten
    // entry; dial 0 goes first since it is selected out of reset.
    send_load(0, -32768, 32767, 255, 32667);  // full range, largest step
    send_load(1, 100, -100, 7, 0);            // inverted limits
    send_load(2, -50, 50, 0, 0);              // zero step
    send_load(3, -10, 10, 3, 500);            // default outside its limits
    for (n = 4; n < NUM_DIALS_DEF; n++)
      send_load(INDEX_W'(n), -$urandom_range(0, 300), $urandom_range(0, 300),
                $urandom_range(1, 20), $urandom_range(0, 100) - 50);

    // Directed ticks under the reset delays (50 first, 10 later).
    send_tick(0, K_RIGHT | K_A, 1'b1, 0);     // doubled 255 saturates, clamps at max
    send_tick(1, K_LEFT | K_Y, 1'b0, 12);     // Y forces step 1, read index out of range
    send_tick(2, K_UP, 1'b1, 3);              // up at dial 0 stays put
    send_tick(3, K_DOWN | K_A | K_X | K_Y | K_B, 1'b0, 1);  // restore all, Y beats A
    send_tick(4, '0, 1'b0, 15);               // release everything
    send_tick(5, K_RIGHT, 1'b0, 1);           // right on inverted limits
    send_tick(6, K_RIGHT | K_LEFT, 1'b0, 1);  // left on inverted limits, right held
    send_tick(55, K_RIGHT | K_LEFT, 1'b1, 1); // right reaches its first repeat
    send_tick(32'hFFFF_FFFA, K_RIGHT | K_LEFT, 1'b0, 1);  // next fire wraps past zero
    send_tick(32'hFFFF_FFFB, K_RIGHT | K_LEFT, 1'b0, 1);  // wrapped deadline compares low
    send_tick(0, K_DOWN, 1'b1, 2);
    send_tick(1, K_RIGHT | K_A, 1'b0, 2);     // zero step doubled is still zero
    send_load(15, $urandom, $urandom, $urandom, $urandom);  // out-of-range load, ignored

    tick     = 1;
    keys     = '0;
    first    = 50;
    again    = 10;
    settings_used = 1;

    // Six delay settings; the first keeps the reset values, the rest include
    // the values 1 and 65535 for each register.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin first = 1;     again = 1;     end
        2: begin first = 65535; again = 65535; end
        3: begin first = 3;     again = 2;     end
        4: begin first = $urandom_range(1, 40); again = $urandom_range(1, 40); end
        5: begin first = 65535; again = 1;     end
        default: ;
      endcase
      if (phase > 0) set_delays(first, again);
      // Advance the tick on the scale of the delays so repeats actually fire.
      adv_max = ((first > again) ? first : again) / 4 + 2;

      for (n = 0; n < 125; n++) begin
        if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // Mid-run, hold the sender once until the result queue is empty.
        if (phase == 3 && n == 60) settle();

        if ($urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1) == 0)
            send_load(INDEX_W'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                      $urandom);
          else
            send_load(INDEX_W'($urandom_range(0, 15)), -$urandom_range(0, 300),
                      $urandom_range(0, 300), $urandom_range(0, 40),
                      $urandom_range(0, 200) - 100);
        end else begin
          case ($urandom_range(0, 39))
            0:       tick = $urandom;                                      // jump anywhere
            1:       tick = 32'hFFFF_FFFF - $urandom_range(0, 2 * adv_max); // near wrap
            default: tick = tick + $urandom_range(0, adv_max);
          endcase
          // Keys mostly stay held across ticks; X is only tapped now and then.
          for (b = 0; b < KEYS_W; b++)
            if ($urandom_range(0, 5) == 0) keys[b] = ~keys[b];
          keys[KEY_X] = ($urandom_range(0, 11) == 0);
          sent_keys = ($urandom_range(0, 14) == 0) ? 8'($urandom) : keys;
          send_tick(tick, sent_keys, $urandom_range(0, 3) == 0,
                    INDEX_W'($urandom_range(0, 15)));
        end
      end
    end

    // Drain and let any late result show up before the verdict.
    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d transactions (%0d dial loads, %0d key ticks) over %0d delay settings",
             loads_sent + ticks_sent, loads_sent, ticks_sent, settings_used);
    $display("%0d results compared, %0d mismatches", dial_compared, dial_mismatches);
    if (dial_mismatches == 0 && dial_waiting == 0) begin
      $display("auto_repeat_dial_editor_core verification clean");
    end else begin
      $display("auto_repeat_dial_editor_core verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("auto_repeat_dial_editor_core verification failed");
    $finish;
  end

endmodule
